[rtl/fqs_pkg.sv]
// Package for the FIFO queue with search.
// Holds the operation codes, field widths and the result record used by the modules.
// Depends on nothing.
package fqs_pkg;

    localparam int KEY_W = 32;
    localparam int POS_W = 4;
    localparam int CNT_W = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // One result transaction as it leaves the controller.
    typedef struct packed {
        logic                     ok;
        logic signed [KEY_W-1:0]  popped_key;
        logic [POS_W-1:0]         found_position;
        logic [CNT_W-1:0]         entry_count;
        logic signed [KEY_W-1:0]  first_key;
        logic signed [KEY_W-1:0]  last_key;
    } t_result;

endpackage

[rtl/fqs_key_mem.sv]
// Key storage of the queue: one write port and one read port with registered read data.
// Depends on fqs_pkg for the key width.
module fqs_key_mem
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic signed [KEY_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic signed [KEY_W-1:0] o_rdata
);

    logic signed [KEY_W-1:0] r_mem [DEPTH];
    logic signed [KEY_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, with registered data valid in the cycle after the request.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fqs_ctrl.sv]
// Queue controller: head, tail and count registers, cached end keys and the search sequencer.
// Depends on fqs_pkg; drives the ports of fqs_key_mem.
module fqs_ctrl
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_op,
    input  logic signed [KEY_W-1:0] i_key_value,
    output logic                    o_mem_we,
    output logic [AW-1:0]           o_mem_waddr,
    output logic signed [KEY_W-1:0] o_mem_wdata,
    output logic                    o_mem_re,
    output logic [AW-1:0]           o_mem_raddr,
    input  logic signed [KEY_W-1:0] i_mem_rdata,
    output logic                    o_res_valid,
    input  logic                    i_res_take,
    output t_result                 o_res
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_POP_RD = 4'b0010,
        S_SEARCH = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_head, n_head;
    logic [AW-1:0]           r_tail, n_tail;
    logic [CW-1:0]           r_count, n_count;
    logic signed [KEY_W-1:0] r_first, n_first;
    logic signed [KEY_W-1:0] r_last, n_last;
    logic signed [KEY_W-1:0] r_skey, n_skey;
    logic [AW-1:0]           r_slot, n_slot;
    logic [AW-1:0]           r_idx, n_idx;
    logic                    r_ok, n_ok;
    logic signed [KEY_W-1:0] r_popped, n_popped;

    logic [AW+POS_W-1:0]     w_pos_ext;
    logic [CW+CNT_W-1:0]     w_cnt_ext;

    // Ring index increment with wrap at the queue depth.
    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot);
        return (slot == AW'(DEPTH - 1)) ? '0 : slot + AW'(1);
    endfunction

    // Next-state logic: one operation per transaction, search walks one entry per cycle.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_first     = r_first;
        n_last      = r_last;
        n_skey      = r_skey;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_popped    = r_popped;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_tail;
        o_mem_wdata = i_key_value;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_ok     = 1'b0;
                    n_popped = '0;
                    n_idx    = '0;
                    n_state  = S_EMIT;
                    case (t_op'(i_op))
                        OP_PUSH: begin
                            if (r_count < CW'(DEPTH)) begin
                                o_mem_we = 1'b1;
                                n_tail   = next_slot(r_tail);
                                n_count  = r_count + CW'(1);
                                n_last   = i_key_value;
                                if (r_count == '0) begin
                                    n_first = i_key_value;
                                end
                                n_ok = 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_count != '0) begin
                                n_popped = r_first;
                                n_head   = next_slot(r_head);
                                n_count  = r_count - CW'(1);
                                n_ok     = 1'b1;
                                if (r_count == CW'(1)) begin
                                    n_first = '0;
                                    n_last  = '0;
                                end else begin
                                    // Fetch the new oldest key.
                                    o_mem_re    = 1'b1;
                                    o_mem_raddr = next_slot(r_head);
                                    n_state     = S_POP_RD;
                                end
                            end
                        end
                        OP_SEARCH: begin
                            n_skey = i_key_value;
                            n_slot = r_head;
                            if (r_count != '0) begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = r_head;
                                n_state     = S_SEARCH;
                            end
                        end
                        OP_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_first = '0;
                            n_last  = '0;
                            n_ok    = 1'b1;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                n_first = i_mem_rdata;
                n_state = S_EMIT;
            end
            S_SEARCH: begin
                // Read data belongs to the entry at position r_idx.
                if (i_mem_rdata == r_skey) begin
                    n_ok    = 1'b1;
                    n_state = S_EMIT;
                end else if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = next_slot(r_slot);
                    n_slot      = next_slot(r_slot);
                    n_idx       = r_idx + AW'(1);
                end
            end
            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_first <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_first <= n_first;
            r_last  <= n_last;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_skey   <= n_skey;
        r_slot   <= n_slot;
        r_idx    <= n_idx;
        r_ok     <= n_ok;
        r_popped <= n_popped;
    end

    // Position and count are reported modulo their field widths.
    assign w_pos_ext = {{POS_W{1'b0}}, r_idx};
    assign w_cnt_ext = {{CNT_W{1'b0}}, r_count};

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);

    always_comb begin
        o_res.ok             = r_ok;
        o_res.popped_key     = r_popped;
        o_res.found_position = r_ok ? w_pos_ext[POS_W-1:0] : '0;
        o_res.entry_count    = w_cnt_ext[CNT_W-1:0];
        o_res.first_key      = r_first;
        o_res.last_key       = r_last;
    end

endmodule

[rtl/fifo_queue_with_search.sv]
// Top level of the FIFO queue with search: controller, key memory and output register.
// Depends on fqs_pkg, fqs_key_mem and fqs_ctrl.
//
// Usage:
// The input channel (i_in_valid, o_in_stall, i_op, i_key_value) carries one operation per
// transaction: push, pop, search or clear. The output channel (o_out_valid, i_out_stall and
// the result fields) returns exactly one result transaction per operation, in order.
// Push and clear pass from acceptance through the controller's result state into the output
// register; a pop that leaves the queue non-empty first reads the new oldest key from the
// key memory. A search reads one entry per cycle through the single read port of the key
// memory and ends at the first match or after the last entry (at once on an empty queue).
// One operation is in progress at a time; the next transaction is accepted once the
// previous result has moved to the output register.
// Reset empties the queue and clears o_out_valid; the key memory is not cleared.
// While the receiver stalls, the output register holds its result; the controller finishes
// the next operation and then waits with its result until the output register frees up.
module fifo_queue_with_search
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_op,
    input  logic signed [KEY_W-1:0] i_key_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_ok,
    output logic signed [KEY_W-1:0] o_popped_key,
    output logic [POS_W-1:0]        o_found_position,
    output logic [CNT_W-1:0]        o_entry_count,
    output logic signed [KEY_W-1:0] o_first_key,
    output logic signed [KEY_W-1:0] o_last_key
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                    w_mem_we;
    logic [AW-1:0]           w_mem_waddr;
    logic signed [KEY_W-1:0] w_mem_wdata;
    logic                    w_mem_re;
    logic [AW-1:0]           w_mem_raddr;
    logic signed [KEY_W-1:0] w_mem_rdata;
    logic                    w_res_valid;
    logic                    w_res_take;
    t_result                 w_res;

    logic                    r_out_valid;
    t_result                 r_out;

    fqs_key_mem #(
        .DEPTH (DEPTH)
    ) u_key_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    fqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_key_value (i_key_value),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res)
    );

    // The output register takes a new result when empty or when its transaction completes.
    assign w_res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_ok             = r_out.ok;
    assign o_popped_key     = r_out.popped_key;
    assign o_found_position = r_out.found_position;
    assign o_entry_count    = r_out.entry_count;
    assign o_first_key      = r_out.first_key;
    assign o_last_key       = r_out.last_key;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the FIFO queue with search.
// Drives push, pop, search and clear transactions against its own queue predictor.
// Depends on fqs_pkg and fifo_queue_with_search.
module tb_top;
    import fqs_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 530;
    localparam int PHASE_LEN    = 40;
    // Receiver hold-off window and a quiet window, both in cycles after reset.
    localparam int HOLD_START   = 300;
    localparam int HOLD_LEN     = 100;
    localparam int QUIET_START  = 1200;
    localparam int QUIET_END    = 1800;
    // Sender runs without gaps over this range of accepted transactions.
    localparam int NO_GAP_FIRST = 260;
    localparam int NO_GAP_LAST  = 380;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        t_op                     op;
        logic signed [KEY_W-1:0] key;
    } queue_cmd_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid  = 1'b0;
    logic [1:0]              i_op        = 2'd0;
    logic signed [KEY_W-1:0] i_key_value = '0;
    logic                    i_out_stall = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic                    o_ok;
    logic signed [KEY_W-1:0] o_popped_key;
    logic [POS_W-1:0]        o_found_position;
    logic [CNT_W-1:0]        o_entry_count;
    logic signed [KEY_W-1:0] o_first_key;
    logic signed [KEY_W-1:0] o_last_key;

    queue_cmd_t cmd_queue[$];
    t_result    expected_results[$];
    int         fail_count     = 0;
    int         accepted_count = 0;
    int         cycle_count    = 0;

    // Shadow copy of the queue contents and pointers.
    logic signed [KEY_W-1:0] shadow_keys [DEPTH];
    logic [3:0]              shadow_head  = '0;
    logic [3:0]              shadow_tail  = '0;
    logic [4:0]              shadow_count = '0;

    logic signed [KEY_W-1:0] key_pool [8];

    fifo_queue_with_search #(.DEPTH(DEPTH)) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_key_value      (i_key_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_ok             (o_ok),
        .o_popped_key     (o_popped_key),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count),
        .o_first_key      (o_first_key),
        .o_last_key       (o_last_key)
    );

    // Apply one operation to the shadow queue and return the result it must produce.
    function automatic t_result apply_queue_op(t_op op, logic signed [KEY_W-1:0] key);
        t_result    res;
        logic [3:0] slot;
        int         idx;
        res = '0;
        case (op)
            OP_PUSH: begin
                if (shadow_count < DEPTH) begin
                    shadow_keys[shadow_tail] = key;
                    shadow_tail  = shadow_tail + 4'd1;
                    shadow_count = shadow_count + 5'd1;
                    res.ok = 1'b1;
                end
            end
            OP_POP: begin
                if (shadow_count != 0) begin
                    res.popped_key = shadow_keys[shadow_head];
                    shadow_head  = shadow_head + 4'd1;
                    shadow_count = shadow_count - 5'd1;
                    res.ok = 1'b1;
                end
            end
            OP_SEARCH: begin
                // The first match from the oldest entry wins.
                slot = shadow_head;
                for (idx = 0; idx < shadow_count; idx++) begin
                    if (!res.ok && shadow_keys[slot] == key) begin
                        res.ok = 1'b1;
                        res.found_position = idx[POS_W-1:0];
                    end
                    slot = slot + 4'd1;
                end
            end
            default: begin
                shadow_head  = '0;
                shadow_tail  = '0;
                shadow_count = '0;
                res.ok = 1'b1;
            end
        endcase
        res.entry_count = shadow_count;
        if (shadow_count != 0) begin
            slot = shadow_tail - 4'd1;
            res.first_key = shadow_keys[shadow_head];
            res.last_key  = shadow_keys[slot];
        end
        return res;
    endfunction

    task automatic add_cmd(t_op op, logic signed [KEY_W-1:0] key);
        queue_cmd_t cmd;
        cmd.op  = op;
        cmd.key = key;
        cmd_queue.push_back(cmd);
    endtask

    // Mostly keys from a small pool so that searches hit and duplicates occur.
    function automatic logic signed [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 60)
            return key_pool[3'($urandom_range(7))];
        return $urandom;
    endfunction

    task automatic check_field(string field, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Safety net against a hung handshake.
    initial begin
        #2000000;
        $display("[fifo_queue_with_search] ERROR");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        int n;
        int mode;
        int roll;
        int push_w;
        int pop_w;
        int total_items;
        i_rst_n = 1'b0;

        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = 32'sh0000_0000;
        key_pool[3] = -32'sd1;
        for (n = 4; n < 8; n++) key_pool[n] = $urandom;

        // Directed part: empty queue, fill to full with extremes, full push,
        // first match over a duplicate, pointer wrap and a miss.
        add_cmd(OP_POP, 32'sh1234_5678);
        add_cmd(OP_SEARCH, 32'sh0000_0000);
        add_cmd(OP_CLEAR, 32'sh7FFF_FFFF);
        add_cmd(OP_PUSH, 32'sh8000_0000);
        add_cmd(OP_PUSH, 32'sh7FFF_FFFF);
        add_cmd(OP_PUSH, 32'sh0000_0000);
        add_cmd(OP_PUSH, -32'sd1);
        add_cmd(OP_PUSH, 32'sh5555_5555);
        add_cmd(OP_PUSH, 32'shAAAA_AAAA);
        add_cmd(OP_PUSH, 32'sh7FFF_FFFF);
        for (n = 1; n <= 8; n++) add_cmd(OP_PUSH, n);
        add_cmd(OP_PUSH, 32'sh1234_5678);
        add_cmd(OP_PUSH, 32'sh0000_0003);
        add_cmd(OP_SEARCH, 32'sh7FFF_FFFF);
        add_cmd(OP_POP, 32'sh0000_0000);
        add_cmd(OP_PUSH, 32'sh0BAD_F00D);
        add_cmd(OP_SEARCH, 32'sh0BAD_F00D);
        add_cmd(OP_SEARCH, 32'sh7FFF_FFFE);
        add_cmd(OP_CLEAR, -32'sd1);

        // Random part in phases that fill, drain or mix the queue.
        mode = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) mode = $urandom_range(2);
            case (mode)
                0:       begin push_w = 60; pop_w = 10; end
                1:       begin push_w = 15; pop_w = 55; end
                default: begin push_w = 35; pop_w = 30; end
            endcase
            roll = $urandom_range(99);
            if (roll >= 97)
                add_cmd(OP_CLEAR, $urandom);
            else if (roll < push_w)
                add_cmd(OP_PUSH, pick_key());
            else if (roll < push_w + pop_w)
                add_cmd(OP_POP, $urandom);
            else
                add_cmd(OP_SEARCH, pick_key());
        end
        total_items = cmd_queue.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transaction to be accepted and for every result.
        while (accepted_count < total_items || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("[fifo_queue_with_search] OK");
        else
            $display("[fifo_queue_with_search] ERROR");
        $finish;
    end

    // Driver: predict on acceptance, then offer the next transaction or idle.
    always @(posedge i_clk) begin : drive_ops
        queue_cmd_t next_cmd;
        logic       gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(apply_queue_op(t_op'(i_op), i_key_value));
                accepted_count++;
            end
            if (!i_in_valid || !o_in_stall) begin
                gap = ($urandom_range(99) < 16) &&
                      !(accepted_count >= NO_GAP_FIRST && accepted_count < NO_GAP_LAST);
                if (cmd_queue.size() != 0 && !gap) begin
                    next_cmd = cmd_queue.pop_front();
                    i_in_valid  <= 1'b1;
                    i_op        <= next_cmd.op;
                    i_key_value <= next_cmd.key;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random, one long hold-off that backs up the block, one quiet stretch.
    always @(posedge i_clk) begin : drive_out_stall
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_LEN)
                i_out_stall <= 1'b1;
            else if (cycle_count >= QUIET_START && cycle_count < QUIET_END)
                i_out_stall <= 1'b0;
            else
                i_out_stall <= ($urandom_range(99) < 16);
        end
    end

    // Monitor: compare each accepted result transaction with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got count %0d",
                         $time, o_entry_count);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("ok", KEY_W'(want.ok), KEY_W'(o_ok));
                check_field("popped_key", want.popped_key, o_popped_key);
                check_field("found_position", KEY_W'(want.found_position),
                            KEY_W'(o_found_position));
                check_field("entry_count", KEY_W'(want.entry_count), KEY_W'(o_entry_count));
                check_field("first_key", want.first_key, o_first_key);
                check_field("last_key", want.last_key, o_last_key);
            end
        end
    end

endmodule
